>>> rtl/core/sscic_pkg.sv
// Shared types, constants and codes for the switch scan and indicator control block.
`default_nettype none

package sscic_pkg;

	localparam int NUM_SWITCHES         = 14;
	localparam int BATTERY_BLINK_SHIFT  = 8;
	localparam int ACTIVITY_BLINK_SHIFT = 4;

	localparam int ROT_INDEX  = 5;
	localparam int LEVEL_BITS = 13;
	localparam int HOLD_W     = 16;
	localparam int DUTY_W     = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LED_LEN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEEP_LEN = 1'd1;

	// Run mode codes.
	localparam logic [2:0] MODE_SAFE     = 3'd0;
	localparam logic [2:0] MODE_RUN_INIT = 3'd1;
	localparam logic [2:0] MODE_RUN      = 3'd2;
	localparam logic [2:0] MODE_FAIL     = 3'd3;

	// Battery mode codes.
	localparam logic [1:0] BAT_LOW = 2'd0;
	localparam logic [1:0] BAT_MID = 2'd1;

	localparam logic [DUTY_W-1:0] RST_RED   = 16'h3FFF;
	localparam logic [DUTY_W-1:0] RST_GREEN = 16'h3FFF;
	localparam logic [DUTY_W-1:0] RST_BLUE  = 16'h0FFF;

	localparam logic [DUTY_W-1:0] OVR_RED   = 16'hAF00;
	localparam logic [DUTY_W-1:0] OVR_GREEN = 16'hAF00;
	localparam logic [DUTY_W-1:0] OVR_BLUE  = 16'h00FF;

	localparam logic [DUTY_W-1:0] SAFE_RED   = 16'h7000;
	localparam logic [DUTY_W-1:0] SAFE_GREEN = 16'h8F00;
	localparam logic [DUTY_W-1:0] SAFE_BLUE  = 16'h8F00;
	localparam logic [DUTY_W-1:0] INIT_RED   = 16'h0040;
	localparam logic [DUTY_W-1:0] INIT_GREEN = 16'h2B00;
	localparam logic [DUTY_W-1:0] INIT_BLUE  = 16'h0400;
	localparam logic [DUTY_W-1:0] RUN_RED    = 16'h0100;
	localparam logic [DUTY_W-1:0] RUN_GREEN  = 16'hF000;
	localparam logic [DUTY_W-1:0] RUN_BLUE   = 16'h1000;
	localparam logic [DUTY_W-1:0] FAIL_RED   = 16'hF000;
	localparam logic [DUTY_W-1:0] FAIL_GREEN = 16'h0800;
	localparam logic [DUTY_W-1:0] FAIL_BLUE  = 16'h0800;
	localparam logic [DUTY_W-1:0] OTHER_DUTY = 16'h0F00;

	typedef struct packed {
		logic        scan_tick;
		logic        frame_tick;
		logic [12:0] switch_levels;
		logic [7:0]  rotary_count;
		logic [3:0]  query_switch;
		logic [15:0] long_press_time;
		logic [2:0]  run_mode;
		logic [1:0]  battery_mode;
		logic        log_on;
	} tick_item_t;

	typedef struct packed {
		logic [12:0] pressed_mask;
		logic [7:0]  rotary_value;
		logic        long_press;
		logic [7:0]  queried_level;
		logic [15:0] red_duty;
		logic [15:0] green_duty;
		logic [15:0] blue_duty;
		logic        battery_led;
		logic        log_led;
		logic        active_led;
		logic        beep_on;
	} result_item_t;

	// Frame event and mode inputs handed to the indicator unit.
	typedef struct packed {
		logic       advance;
		logic       frame;
		logic       change;
		logic [2:0] run_mode;
		logic [1:0] battery_mode;
		logic       log_on;
	} frame_evt_t;

	// Indicator state as it stands after the current item.
	typedef struct packed {
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
		logic              battery_led;
		logic              log_led;
		logic              active_led;
		logic              beep_on;
	} ind_state_t;

endpackage

`default_nettype wire

>>> rtl/core/sscic_hold_lane.sv
// One hold counter lane: saturating up/down count of a switch and its long-press compare.
`default_nettype none

module sscic_hold_lane (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic                      pressed,
	input  wire logic [sscic_pkg::HOLD_W-1:0] threshold,
	output logic                           at_threshold
);
	import sscic_pkg::*;

	logic [HOLD_W-1:0] count_q;
	logic [HOLD_W-1:0] count_next;

	always_comb begin
		count_next = count_q;
		if (advance) begin
			if (pressed && count_q != HOLD_MAX) begin
				count_next = count_q + HOLD_W'(1);
			end else if (!pressed && count_q != '0) begin
				count_next = count_q - HOLD_W'(1);
			end
		end
	end

	assign at_threshold = (count_next >= threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sscic_merge.sv
// Merges the lane results: picks the long-press flag and level of the queried switch.
`default_nettype none

module sscic_merge (
	input  wire logic [sscic_pkg::NUM_SWITCHES-1:0] lane_hit,
	input  wire logic [sscic_pkg::NUM_SWITCHES-1:0] lane_pressed,
	input  wire logic [7:0]                         rotary,
	input  wire logic [3:0]                         query,
	output logic                                    long_press,
	output logic [7:0]                              queried_level
);
	import sscic_pkg::*;

	// A query beyond the last lane matches nothing and reads as zero.
	always_comb begin
		long_press    = 1'b0;
		queried_level = '0;
		for (int k = 0; k < NUM_SWITCHES; k++) begin
			if (int'(query) == k) begin
				long_press = lane_hit[k];
				if (k == ROT_INDEX) begin
					queried_level = rotary;
				end else begin
					queried_level = {7'd0, lane_pressed[k]};
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sscic_indicator.sv
// Frame unit: RGB duties with feedback override, battery and activity LEDs, feedback beep.
`default_nettype none

module sscic_indicator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [sscic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                  cfg_data,
	input  wire sscic_pkg::frame_evt_t        evt,
	output sscic_pkg::ind_state_t             state_next
);
	import sscic_pkg::*;

	logic [15:0] led_len_q;
	logic [15:0] beep_len_q;

	logic        ovr_active_q;
	logic [15:0] ovr_count_q;
	logic        beep_active_q;
	logic [15:0] beep_count_q;
	logic [15:0] bat_count_q;
	logic [15:0] act_count_q;
	ind_state_t  state_q;

	logic        ovr_active_next;
	logic [15:0] ovr_count_next;
	logic        beep_active_next;
	logic [15:0] beep_count_next;
	logic [15:0] bat_count_next;
	logic [15:0] act_count_next;
	logic [15:0] bat_step;
	logic        blink;

	always_comb begin
		state_next       = state_q;
		ovr_count_next   = ovr_count_q;
		beep_count_next  = beep_count_q;
		bat_count_next   = bat_count_q;
		act_count_next   = act_count_q;
		// A change seen at this item's scan arms both feedback timers before the frame.
		ovr_active_next  = ovr_active_q | evt.change;
		beep_active_next = beep_active_q | evt.change;
		bat_step         = bat_count_q + 16'd1;
		blink            = act_count_q[ACTIVITY_BLINK_SHIFT];

		if (evt.frame) begin
			unique case (evt.run_mode)
				MODE_SAFE: begin
					state_next.red   = SAFE_RED;
					state_next.green = SAFE_GREEN;
					state_next.blue  = SAFE_BLUE;
				end
				MODE_RUN_INIT: begin
					state_next.red   = INIT_RED;
					state_next.green = INIT_GREEN;
					state_next.blue  = INIT_BLUE;
				end
				MODE_RUN: begin
					state_next.red   = RUN_RED;
					state_next.green = RUN_GREEN;
					state_next.blue  = RUN_BLUE;
				end
				MODE_FAIL: begin
					state_next.red   = FAIL_RED;
					state_next.green = FAIL_GREEN;
					state_next.blue  = FAIL_BLUE;
				end
				default: begin
					state_next.red   = OTHER_DUTY;
					state_next.green = OTHER_DUTY;
					state_next.blue  = OTHER_DUTY;
				end
			endcase

			if (ovr_active_next) begin
				state_next.red   = OVR_RED;
				state_next.green = OVR_GREEN;
				state_next.blue  = OVR_BLUE;
				if (ovr_count_q > led_len_q) begin
					ovr_count_next  = '0;
					ovr_active_next = 1'b0;
				end else begin
					ovr_count_next = ovr_count_q + 16'd1;
				end
			end

			// Mid battery advances twice and shows the bit after the first step.
			if (evt.battery_mode == BAT_LOW) begin
				state_next.battery_led = 1'b1;
				bat_count_next         = bat_step;
			end else if (evt.battery_mode == BAT_MID) begin
				state_next.battery_led = bat_step[BATTERY_BLINK_SHIFT];
				bat_count_next         = bat_count_q + 16'd2;
			end else begin
				state_next.battery_led = 1'b0;
				bat_count_next         = bat_step;
			end

			act_count_next        = act_count_q + 16'd1;
			state_next.log_led    = evt.log_on & blink;
			state_next.active_led = ~evt.log_on & blink;

			if (beep_active_next) begin
				if (beep_count_q > beep_len_q) begin
					state_next.beep_on = 1'b0;
					beep_count_next    = '0;
					beep_active_next   = 1'b0;
				end else begin
					state_next.beep_on = 1'b1;
					beep_count_next    = beep_count_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_len_q           <= 16'd10;
			beep_len_q          <= 16'd10;
			ovr_active_q        <= 1'b0;
			ovr_count_q         <= '0;
			beep_active_q       <= 1'b0;
			beep_count_q        <= '0;
			bat_count_q         <= '0;
			act_count_q         <= '0;
			state_q.red         <= RST_RED;
			state_q.green       <= RST_GREEN;
			state_q.blue        <= RST_BLUE;
			state_q.battery_led <= 1'b0;
			state_q.log_led     <= 1'b0;
			state_q.active_led  <= 1'b0;
			state_q.beep_on     <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_LED_LEN:  led_len_q  <= cfg_data;
					CFG_BEEP_LEN: beep_len_q <= cfg_data;
				endcase
			end
			if (evt.advance) begin
				ovr_active_q  <= ovr_active_next;
				ovr_count_q   <= ovr_count_next;
				beep_active_q <= beep_active_next;
				beep_count_q  <= beep_count_next;
				bat_count_q   <= bat_count_next;
				act_count_q   <= act_count_next;
				state_q       <= state_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/switch_scan_and_indicator_control.sv
// Top level: switch scan latches, hold counter lanes, indicator unit and result buffering.
//
//  Channel   Direction  Signals                                    Moves
//  tick      in         tick_valid, tick_ready, tick               one scan/frame tick item
//  result    out        result_valid, result_ready, result         one result item per tick
//  cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data  feedback length writes
//
// Every tick item is handled as it is taken: the 14 hold counter lanes and the indicator
// unit update in parallel, and the result is registered at the edge that takes the item.
// One item per cycle is sustained while result_ready stays high; a two-entry output
// stage (result register plus skid register) lets one more item in during a stall.
// After reset all counters are zero, the duties hold their power-up colors and no
// result is pending. Configuration writes are always taken, as cfg_ready is tied high.
`default_nettype none

module switch_scan_and_indicator_control (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             tick_valid,
	output logic                                  tick_ready,
	input  wire sscic_pkg::tick_item_t            tick,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output sscic_pkg::result_item_t               result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sscic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                      cfg_data
);
	import sscic_pkg::*;

	logic                    tick_fire;
	logic                    scan_fire;
	logic [LEVEL_BITS-1:0]   last_levels_q;
	logic [7:0]              last_rotary_q;
	logic [LEVEL_BITS-1:0]   pressed_next;
	logic [7:0]              rotary_next;
	logic                    change;
	logic [NUM_SWITCHES-1:0] lane_pressed;
	logic [NUM_SWITCHES-1:0] lane_hit;
	logic                    long_press;
	logic [7:0]              queried_level;
	frame_evt_t              evt;
	ind_state_t              ind_next;
	result_item_t            result_next;
	result_item_t            result_q;
	result_item_t            skid_q;
	logic                    result_valid_q;
	logic                    skid_full_q;

	assign tick_ready = ~skid_full_q;
	assign tick_fire  = tick_valid & tick_ready;
	assign scan_fire  = tick_fire & tick.scan_tick;
	assign cfg_ready  = 1'b1;

	assign pressed_next = tick.scan_tick ? ~tick.switch_levels : last_levels_q;
	assign rotary_next  = tick.scan_tick ? tick.rotary_count : last_rotary_q;
	assign change = tick.scan_tick &&
		((~tick.switch_levels != last_levels_q) || (tick.rotary_count != last_rotary_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q <= '0;
			last_rotary_q <= '0;
		end else if (scan_fire) begin
			last_levels_q <= pressed_next;
			last_rotary_q <= rotary_next;
		end
	end

	// Switch indexes skip the rotary slot; lanes with no level bit read released.
	for (genvar k = 0; k < NUM_SWITCHES; k++) begin : g_lane
		localparam int LevelBit = (k < ROT_INDEX) ? k : k - 1;

		if (k == ROT_INDEX) begin : g_rot
			assign lane_pressed[k] = (rotary_next != '0);
		end else if (LevelBit < LEVEL_BITS) begin : g_sw
			assign lane_pressed[k] = pressed_next[LevelBit];
		end else begin : g_none
			assign lane_pressed[k] = 1'b0;
		end

		sscic_hold_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (scan_fire),
			.pressed      (lane_pressed[k]),
			.threshold    (tick.long_press_time),
			.at_threshold (lane_hit[k])
		);
	end

	sscic_merge u_merge (
		.lane_hit      (lane_hit),
		.lane_pressed  (lane_pressed),
		.rotary        (rotary_next),
		.query         (tick.query_switch),
		.long_press    (long_press),
		.queried_level (queried_level)
	);

	assign evt.advance      = tick_fire;
	assign evt.frame        = tick.frame_tick;
	assign evt.change       = change;
	assign evt.run_mode     = tick.run_mode;
	assign evt.battery_mode = tick.battery_mode;
	assign evt.log_on       = tick.log_on;

	sscic_indicator u_indicator (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.evt        (evt),
		.state_next (ind_next)
	);

	always_comb begin
		result_next.pressed_mask  = pressed_next;
		result_next.rotary_value  = rotary_next;
		result_next.long_press    = long_press;
		result_next.queried_level = queried_level;
		result_next.red_duty      = ind_next.red;
		result_next.green_duty    = ind_next.green;
		result_next.blue_duty     = ind_next.blue;
		result_next.battery_led   = ind_next.battery_led;
		result_next.log_led       = ind_next.log_led;
		result_next.active_led    = ind_next.active_led;
		result_next.beep_on       = ind_next.beep_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_full_q    <= 1'b0;
		end else if (tick_fire) begin
			if (!result_valid_q || result_ready) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (result_valid_q && result_ready) begin
			if (skid_full_q) begin
				skid_full_q <= 1'b0;
			end else begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire && (!result_valid_q || result_ready)) begin
			result_q <= result_next;
		end else if (result_valid_q && result_ready && skid_full_q) begin
			result_q <= skid_q;
		end
		if (tick_fire && result_valid_q && !result_ready) begin
			skid_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
